### sv/indexed_priority_task_table_assert.svh
// Assertion macros for the indexed priority task table.
// They expand to concurrent assertions in simulation and to nothing in synthesis.
// Needs no other file.
`ifndef INDEXED_PRIORITY_TASK_TABLE_ASSERT_SVH
`define INDEXED_PRIORITY_TASK_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
// When cond holds, prop must hold in the same cycle.
`define IPTT_ASSERT_IMPLY(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);
// When cond holds, prop must hold in the next cycle.
`define IPTT_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);
`else
`define IPTT_ASSERT_IMPLY(label, clk, rstn, cond, prop, msg)
`define IPTT_ASSERT_NEXT(label, clk, rstn, cond, prop, msg)
`endif
`endif

### sv/iptt_pkg.sv
// Shared types and constants of the indexed priority task table.
// Used by the top level; depends on nothing.
`default_nettype none

package iptt_pkg;

    // Table geometry.
    localparam int TASK_SLOTS = 1024;
    localparam int PRIO_BITS  = 16;
    localparam int USER_BITS  = 16;
    localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
    localparam int CNT_BITS   = SLOT_BITS + 1;
    localparam int ENTRY_BITS = 1 + PRIO_BITS + USER_BITS;

    // Stream field widths.
    localparam int KIND_BITS     = 2;
    localparam int TASK_ID_BITS  = 10;
    localparam int USER_ID_BITS  = 16;
    localparam int PRIO_REQ_BITS = 16;
    localparam int OWNER_BITS    = 16;
    localparam int S_TDATA_BITS  = 48;
    localparam int M_TDATA_BITS  = 16;

    // Operation codes carried on s_tuser.
    typedef enum logic [KIND_BITS-1:0] {
        KIND_ADD    = 2'd0,
        KIND_EDIT   = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_EXEC   = 2'd3
    } kind_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDIT,
        ST_SCAN,
        ST_FINISH
    } state_t;

    // One table entry as stored in the memory.
    typedef struct packed {
        logic                 valid;
        logic [PRIO_BITS-1:0] prio;
        logic [USER_BITS-1:0] user;
    } entry_t;

endpackage

`default_nettype wire

### sv/indexed_priority_task_table.sv
// Top level of the indexed priority task table: sequencer, scan compare unit
// and output register. Depends on iptt_pkg, iptt_ram and the assertion header.
//
// Channel  Dir  Fields (tdata / tuser)                          Handshake
// s_       in   task_id, user_id, priority_req / kind           s_tvalid, s_tready
// m_       out  owner / found                                   m_tvalid, m_tready
//
// Add and remove are done on acceptance, edit reads then writes back, execute
// top accepts, then takes TASK_SLOTS + 1 scan steps through one compare unit
// reading the table one slot per cycle, then a step that clears the winner.
// After reset a clearing pass writes every slot invalid, during which no word
// is accepted. A finished result waits in the output register; a following
// execute top holds in its last step while it is full.
`default_nettype none
`include "indexed_priority_task_table_assert.svh"

module indexed_priority_task_table (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [9:0] task_id, [25:10] user_id, [41:26] priority_req, [47:42] zero
    input  wire logic [47:0] s_tdata,
    // [1:0] kind
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] owner
    output logic [15:0]      m_tdata,
    // [0] found
    output logic [0:0]       m_tuser
);

    localparam int SB = iptt_pkg::SLOT_BITS;
    localparam int CB = iptt_pkg::CNT_BITS;

    iptt_pkg::state_t state_reg, state_next;

    logic [CB-1:0] cnt_reg, cnt_next;
    logic          any_reg, any_next;
    logic [SB-1:0] best_slot_reg, best_slot_next;
    logic [iptt_pkg::PRIO_BITS-1:0] best_prio_reg, best_prio_next;
    logic [iptt_pkg::USER_BITS-1:0] best_user_reg, best_user_next;
    logic [SB-1:0] slot_reg, slot_next;
    logic [iptt_pkg::PRIO_BITS-1:0] prio_reg, prio_next;

    logic                               m_valid_reg, m_valid_next;
    logic                               found_reg, found_next;
    logic [iptt_pkg::OWNER_BITS-1:0]    owner_reg, owner_next;

    logic          wr_en;
    logic [SB-1:0] wr_addr;
    iptt_pkg::entry_t wr_entry;
    logic [SB-1:0] rd_addr;
    iptt_pkg::entry_t rd_entry;

    logic                  s_accept;
    iptt_pkg::kind_t       in_kind;
    logic                  in_table;
    logic [SB-1:0]         in_slot;
    logic [iptt_pkg::PRIO_BITS-1:0] in_prio;
    logic [iptt_pkg::USER_BITS-1:0] in_user;
    logic                  out_free;
    logic                  out_load;
    logic                  scan_take;
    logic [SB-1:0]         prev_slot;

    // Input word decode.
    assign s_accept = s_tvalid && s_tready;
    assign in_kind  = iptt_pkg::kind_t'(s_tuser);
    assign in_table = 32'(s_tdata[9:0]) < 32'(iptt_pkg::TASK_SLOTS);
    assign in_slot  = SB'(s_tdata[9:0]);
    assign in_user  = iptt_pkg::USER_BITS'(s_tdata[25:10]);
    assign in_prio  = iptt_pkg::PRIO_BITS'(s_tdata[41:26]);
    assign out_free = !m_valid_reg || m_tready;

    // Shared compare unit: the word read last cycle belongs to slot cnt - 1.
    assign prev_slot = SB'(cnt_reg - CB'(1));
    assign scan_take = (cnt_reg != '0) && rd_entry.valid &&
                       (!any_reg || (rd_entry.prio >= best_prio_reg));

    // Table memory.
    iptt_ram #(
        .WIDTH (iptt_pkg::ENTRY_BITS),
        .DEPTH (iptt_pkg::TASK_SLOTS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_addr (rd_addr),
        .rd_data (rd_entry)
    );

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            iptt_pkg::ST_CLEAR: begin
                if (cnt_reg == CB'(iptt_pkg::TASK_SLOTS - 1)) begin
                    state_next = iptt_pkg::ST_IDLE;
                end
            end
            iptt_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (in_kind == iptt_pkg::KIND_EDIT && in_table) begin
                        state_next = iptt_pkg::ST_EDIT;
                    end else if (in_kind == iptt_pkg::KIND_EXEC) begin
                        state_next = iptt_pkg::ST_SCAN;
                    end
                end
            end
            iptt_pkg::ST_EDIT: begin
                state_next = iptt_pkg::ST_IDLE;
            end
            iptt_pkg::ST_SCAN: begin
                if (cnt_reg == CB'(iptt_pkg::TASK_SLOTS)) begin
                    state_next = iptt_pkg::ST_FINISH;
                end
            end
            iptt_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = iptt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = iptt_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control per state.
    always_comb begin
        s_tready       = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = slot_reg;
        wr_entry       = '0;
        rd_addr        = slot_reg;
        cnt_next       = cnt_reg;
        any_next       = any_reg;
        best_slot_next = best_slot_reg;
        best_prio_next = best_prio_reg;
        best_user_next = best_user_reg;
        slot_next      = slot_reg;
        prio_next      = prio_reg;
        out_load       = 1'b0;
        unique case (state_reg)
            iptt_pkg::ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg[SB-1:0];
                if (cnt_reg == CB'(iptt_pkg::TASK_SLOTS - 1)) begin
                    cnt_next = '0;
                end else begin
                    cnt_next = cnt_reg + CB'(1);
                end
            end
            iptt_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                rd_addr  = in_slot;
                if (s_accept) begin
                    slot_next = in_slot;
                    prio_next = in_prio;
                    unique case (in_kind)
                        iptt_pkg::KIND_ADD: begin
                            wr_en          = in_table;
                            wr_addr        = in_slot;
                            wr_entry.valid = 1'b1;
                            wr_entry.prio  = in_prio;
                            wr_entry.user  = in_user;
                        end
                        iptt_pkg::KIND_EDIT: begin
                            // The read issued here is checked in the next cycle.
                        end
                        iptt_pkg::KIND_REMOVE: begin
                            wr_en   = in_table;
                            wr_addr = in_slot;
                        end
                        iptt_pkg::KIND_EXEC: begin
                            cnt_next = '0;
                            any_next = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            iptt_pkg::ST_EDIT: begin
                // Write back the new priority only if the entry is present.
                wr_en          = rd_entry.valid;
                wr_entry.valid = 1'b1;
                wr_entry.prio  = prio_reg;
                wr_entry.user  = rd_entry.user;
            end
            iptt_pkg::ST_SCAN: begin
                rd_addr  = cnt_reg[SB-1:0];
                cnt_next = cnt_reg + CB'(1);
                if (scan_take) begin
                    any_next       = 1'b1;
                    best_slot_next = prev_slot;
                    best_prio_next = rd_entry.prio;
                    best_user_next = rd_entry.user;
                end
            end
            iptt_pkg::ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    wr_en    = any_reg;
                    wr_addr  = best_slot_reg;
                end
            end
            default: begin
            end
        endcase
    end

    // Output register.
    always_comb begin
        found_next = found_reg;
        owner_next = owner_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            found_next   = any_reg;
            owner_next   = any_reg ? iptt_pkg::OWNER_BITS'(best_user_reg) : '0;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iptt_pkg::ST_CLEAR;
            cnt_reg     <= '0;
            any_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            any_reg     <= any_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        best_slot_reg <= best_slot_next;
        best_prio_reg <= best_prio_next;
        best_user_reg <= best_user_next;
        slot_reg      <= slot_next;
        prio_reg      <= prio_next;
        found_reg     <= found_next;
        owner_reg     <= owner_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = owner_reg;
    assign m_tuser[0] = found_reg;

    // Assertions.
    `IPTT_ASSERT_NEXT(a_finish_loads, aclk, aresetn, (state_reg == iptt_pkg::ST_FINISH) && out_free, m_tvalid, "finished scan did not load a result")
    `IPTT_ASSERT_IMPLY(a_empty_owner, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata == '0, "owner not zero for an empty table")
    `IPTT_ASSERT_IMPLY(a_scan_range, aclk, aresetn, state_reg == iptt_pkg::ST_SCAN, cnt_reg <= CB'(iptt_pkg::TASK_SLOTS), "scan counter out of range")
    `IPTT_ASSERT_IMPLY(a_scan_no_write, aclk, aresetn, state_reg == iptt_pkg::ST_SCAN, !wr_en, "table written during a scan")

endmodule

`default_nettype wire

### sv/iptt_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module iptt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 aclk,
    input  wire logic                 wr_en,
    input  wire logic [ADDR_BITS-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]     wr_data,
    input  wire logic [ADDR_BITS-1:0] rd_addr,
    output logic      [WIDTH-1:0]     rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### verif/indexed_priority_task_table_test.sv
// Self-checking testbench for the indexed priority task table.
// Drives add, edit, remove and execute-top words and checks every result against a predictor or a hand-typed result.
// Depends on iptt_pkg and the indexed_priority_task_table top level.
`timescale 1ns / 100ps

module indexed_priority_task_table_test;

    localparam int RANDOM_WORDS = 560;
    localparam int CHOKE_AT     = 300;
    localparam int CHOKE_CYCLES = 4000;
    localparam int DRAIN_CYCLES = 2 * iptt_pkg::TASK_SLOTS + 64;

    // One result of execute top.
    typedef struct packed {
        logic                            found;
        logic [iptt_pkg::OWNER_BITS-1:0] owner;
    } grant_t;

    // One stimulus word, with an optional hand-typed result.
    typedef struct packed {
        iptt_pkg::kind_t                    kind;
        logic [iptt_pkg::TASK_ID_BITS-1:0]  task_id;
        logic [iptt_pkg::USER_ID_BITS-1:0]  user_id;
        logic [iptt_pkg::PRIO_REQ_BITS-1:0] prio;
        logic                               typed;
        grant_t                             grant;
    } stim_row_t;

    // Directed words: empty table, ignored edit and remove, field extremes,
    // ties broken by the greater id, overwrite by add, edit of a live entry.
    localparam stim_row_t DIRECTED [20] = '{
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_REMOVE, 10'h005, 16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EDIT,   10'h007, 16'h0000, 16'hFFFF, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h000, 16'hFFFF, 16'h0000, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h3FF, 16'h0000, 16'hFFFF, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h200, 16'h1234, 16'hFFFF, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h1234}},
        '{iptt_pkg::KIND_EDIT,   10'h000, 16'h0000, 16'hAAAA, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h2AA, 16'h5555, 16'h5555, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h155, 16'hAAAA, 16'hAAAA, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h3FF, 16'hFFFF, 16'hFFFF, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_REMOVE, 10'h2AA, 16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h003, 16'h0007, 16'h0009, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_ADD,    10'h003, 16'h0008, 16'h0001, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EDIT,   10'h003, 16'h0000, 16'h0004, 1'b0, '{1'b0, 16'h0000}},
        '{iptt_pkg::KIND_EXEC,   10'h000, 16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000}}
    };

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic [0:0]  m_tuser;

    // Predictor copy of the task table.
    bit                             live [iptt_pkg::TASK_SLOTS];
    logic [iptt_pkg::PRIO_BITS-1:0] live_prio [iptt_pkg::TASK_SLOTS];
    logic [iptt_pkg::USER_BITS-1:0] live_user [iptt_pkg::TASK_SLOTS];

    grant_t owed_grants[$];
    int     grant_errors;
    bit     steady;
    bit     choke_now;
    bit     choke_done;

    indexed_priority_task_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // Gap length: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int r;
        r = $urandom_range(99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Applies one operation to the predicted table; returns 1 when execute top
    // yields a grant. Ties go to the greater id because the scan keeps >=.
    function automatic bit apply_task_op(input stim_row_t row, output grant_t grant);
        bit                             any;
        int                             best;
        logic [iptt_pkg::PRIO_BITS-1:0] best_prio;
        grant = '0;
        case (row.kind)
            iptt_pkg::KIND_ADD: begin
                live_prio[row.task_id] = row.prio;
                live_user[row.task_id] = row.user_id;
                live[row.task_id]      = 1'b1;
                return 1'b0;
            end
            iptt_pkg::KIND_EDIT: begin
                if (live[row.task_id]) live_prio[row.task_id] = row.prio;
                return 1'b0;
            end
            iptt_pkg::KIND_REMOVE: begin
                live[row.task_id] = 1'b0;
                return 1'b0;
            end
            default: begin
                any       = 1'b0;
                best      = 0;
                best_prio = '0;
                for (int k = 0; k < iptt_pkg::TASK_SLOTS; k++) begin
                    if (live[k] && (!any || live_prio[k] >= best_prio)) begin
                        any       = 1'b1;
                        best      = k;
                        best_prio = live_prio[k];
                    end
                end
                if (any) begin
                    live[best]  = 1'b0;
                    grant.found = 1'b1;
                    grant.owner = live_user[best];
                end
                return 1'b1;
            end
        endcase
    endfunction

    // Offers one word after a random gap, waits for it to be taken, then
    // records the grant it is owed. Called right after a rising edge.
    task automatic offer_word(input stim_row_t row);
        int     gap;
        grant_t grant;
        gap = idle_cycles();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, row.prio, row.user_id, row.task_id};
        s_tuser  <= row.kind;
        do @(posedge aclk); while (!s_tready);
        if (apply_task_op(row, grant))
            owed_grants.push_back(row.typed ? row.grant : grant);
    endtask

    // Random word: mostly a small pool of hot ids and few priority levels,
    // so that edits hit live entries and ties are common.
    function automatic stim_row_t random_word(input int idx);
        stim_row_t row;
        int        r;
        int        id_pick;
        row = '0;
        r = $urandom_range(99);
        if (idx >= CHOKE_AT && idx < CHOKE_AT + 8) row.kind = iptt_pkg::KIND_EXEC;
        else if (r < 40)                           row.kind = iptt_pkg::KIND_ADD;
        else if (r < 58)                           row.kind = iptt_pkg::KIND_EDIT;
        else if (r < 72)                           row.kind = iptt_pkg::KIND_REMOVE;
        else                                       row.kind = iptt_pkg::KIND_EXEC;
        r = $urandom_range(99);
        if (r < 70)
            id_pick = $urandom_range(1) ? $urandom_range(15)
                                        : iptt_pkg::TASK_SLOTS - 1 - $urandom_range(15);
        else
            id_pick = $urandom_range(iptt_pkg::TASK_SLOTS - 1);
        row.task_id = iptt_pkg::TASK_ID_BITS'(id_pick);
        row.user_id = iptt_pkg::USER_ID_BITS'($urandom);
        r = $urandom_range(99);
        if (r < 50)
            row.prio = iptt_pkg::PRIO_REQ_BITS'($urandom_range(7));
        else if (r < 60)
            row.prio = iptt_pkg::PRIO_REQ_BITS'(32'hFFFF - $urandom_range(3));
        else
            row.prio = iptt_pkg::PRIO_REQ_BITS'($urandom);
        return row;
    endfunction

    // Result side: each taken word is checked against the oldest owed grant.
    always @(posedge aclk) begin
        grant_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (owed_grants.size() == 0) begin
                $error("unexpected result word: found %0d owner 0x%04h", m_tuser[0], m_tdata);
                grant_errors++;
            end else begin
                want = owed_grants.pop_front();
                if (m_tuser[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
                    grant_errors++;
                end
                if (m_tdata !== want.owner) begin
                    $error("owner: expected 0x%04h, got 0x%04h", want.owner, m_tdata);
                    grant_errors++;
                end
            end
        end
    end

    // Receiver: random stalls, one long hold-off to back the block up.
    initial begin : result_sink
        int n;
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (choke_now && !choke_done) begin
                m_tready   <= 1'b0;
                choke_done = 1'b1;
                repeat (CHOKE_CYCLES) @(negedge aclk);
            end else if (!steady && $urandom_range(7) == 0) begin
                m_tready <= 1'b0;
                n = idle_cycles();
                repeat (n) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on the whole run.
    initial begin : watchdog
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Reset, directed table, random words, then drain.
    initial begin : stimulus
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = iptt_pkg::KIND_ADD;
        aresetn      = 1'b0;
        grant_errors = 0;
        steady       = 1'b0;
        choke_now    = 1'b0;
        choke_done   = 1'b0;
        foreach (live[k]) live[k] = 1'b0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) offer_word(DIRECTED[i]);

        for (int i = 0; i < RANDOM_WORDS; i++) begin
            steady = (i >= 100 && i < 180);
            if (i == CHOKE_AT) choke_now = 1'b1;
            offer_word(random_word(i));
        end
        steady = 1'b0;
        @(negedge aclk);
        s_tvalid <= 1'b0;

        while (owed_grants.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (grant_errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
